// ----- design/hsvc_pkg.sv -----
`default_nettype none

package hsvc_pkg;

    localparam int unsigned HUE_MAX    = 360;
    localparam int unsigned PCT_MAX    = 100;
    localparam int unsigned SECTOR_DEG = 60;
    localparam int unsigned SECTORS    = 6;
    // full scale of every numerator term: 100 * 60
    localparam int unsigned K_FULL     = 6000;
    // common denominator 600000 reduced by 64, with the half-step bias for rounding
    localparam int unsigned ROUND_DIV  = 9375;
    localparam int unsigned ROUND_BIAS = 4687;
    localparam int unsigned ROUND_DIV_W = 14;

    localparam int unsigned HUE_W   = 9;
    localparam int unsigned PCT_W   = 7;
    localparam int unsigned REM_W   = 6;
    localparam int unsigned K_W     = 13;
    localparam int unsigned PROD_W  = 20;
    localparam int unsigned LEVEL_W = 13;

    typedef struct packed {
        logic               led_on;
        logic [HUE_W-1:0]   hue_degrees;
        logic [PCT_W-1:0]   saturation_pct;
        logic [PCT_W-1:0]   value_pct;
    } t_hsv_item;

    typedef struct packed {
        logic [LEVEL_W-1:0] red_level;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] blue_level;
        logic               in_range;
    } t_rgb_item;

endpackage

`default_nettype wire

// ----- design/hsvc_ifs.sv -----
`default_nettype none

interface hsvc_hsv_if;
    logic                 valid;
    logic                 ready;
    hsvc_pkg::t_hsv_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hsvc_rgb_if;
    logic                 valid;
    logic                 ready;
    hsvc_pkg::t_rgb_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/hsvc_scale.sv -----
`default_nettype none

// three-stage rounding divide of a numerator by 600000, scaled by 2^FRAC_BITS
module hsvc_scale #(
    parameter int unsigned FRAC_BITS = 12
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_en,
    input  wire logic [hsvc_pkg::PROD_W-1:0]    i_prod,
    output logic      [hsvc_pkg::LEVEL_W-1:0]   o_level
);
    import hsvc_pkg::*;

    localparam int unsigned ZW  = FRAC_BITS + 14;
    localparam int unsigned SH  = ZW;
    localparam int unsigned MW  = FRAC_BITS + 1;
    localparam int unsigned QW  = FRAC_BITS + 1;
    localparam int unsigned PW  = ZW + MW;
    localparam int unsigned P2W = QW + ROUND_DIV_W;
    localparam int unsigned EW  = (QW > LEVEL_W) ? QW : LEVEL_W;
    localparam logic [MW-1:0] RECIP = MW'((64'd1 << SH) / 64'(ROUND_DIV));

    logic [ZW-1:0]  r_za, r_zb, r_zc;
    logic [QW-1:0]  r_qb, r_qc;
    logic [P2W-1:0] r_p2;
    logic [ZW-1:0]  n_za;
    logic [PW-1:0]  w_prod;
    logic [P2W-1:0] w_p2, w_rem;
    logic [QW-1:0]  w_q;
    logic [EW-1:0]  w_qx;

    // scaled numerator plus rounding bias
    assign n_za   = (ZW'(i_prod) << (FRAC_BITS - 6)) + ZW'(ROUND_BIAS);
    // reciprocal estimate, at most one short of the true quotient
    assign w_prod = PW'(r_za) * PW'(RECIP);
    assign w_p2   = P2W'(r_qb) * P2W'(ROUND_DIV);
    assign w_rem  = P2W'(r_zc) - r_p2;
    assign w_q    = r_qc + QW'(w_rem >= P2W'(ROUND_DIV));
    assign w_qx   = EW'(w_q);
    assign o_level = w_qx[LEVEL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_za <= n_za;
            r_zb <= r_za;
            r_qb <= w_prod[SH +: QW];
            r_zc <= r_zb;
            r_qc <= r_qb;
            r_p2 <= w_p2;
        end
    end

endmodule

`default_nettype wire

// ----- design/hsv_to_rgb_converter_top.sv -----
`default_nettype none

// hsv to rgb colour converter. each item carries an led enable flag, a hue in degrees and a
// saturation and value in percent; each result gives red, green and blue with FRAC_BITS
// fraction bits (4096 is full intensity at the default), rounded to nearest with ties up,
// plus an in_range flag. hue above 360 and saturation or value above 100 are clamped
// before conversion and clear in_range. led off gives black but in_range is still
// reported. a hue of 360 wraps to red. one item is taken every cycle while the output
// is not stalled; each result passes through seven register stages (sector split, term
// build, value multiply, three-stage reciprocal divide, output register), the first of
// which loads on the accepting edge. the whole pipeline holds while the output item
// waits to be taken; no item is taken during reset.
module hsv_to_rgb_converter_top #(
    parameter int unsigned FRAC_BITS = 12
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    hsvc_hsv_if.sink    i_hsv,
    hsvc_rgb_if.source  o_rgb
);
    import hsvc_pkg::*;

    localparam int unsigned DEPTH = 6;

    // colour sectors of the hue circle, 60 degrees each
    typedef enum logic [2:0] {
        SEC_R_Y = 3'd0,
        SEC_Y_G = 3'd1,
        SEC_G_C = 3'd2,
        SEC_C_B = 3'd3,
        SEC_B_M = 3'd4,
        SEC_M_R = 3'd5
    } t_sector;

    // item details that ride alongside the arithmetic
    typedef struct packed {
        logic    led_on;
        logic    in_range;
        t_sector sector;
    } t_side;

    // pipeline control: everything moves together unless the output is stalled
    logic               w_en;
    logic [DEPTH-1:0]   r_vld;
    t_side              r_side [DEPTH];
    logic               r_out_vld;
    t_rgb_item          r_out;
    t_rgb_item          n_out;

    // stage 1: clamp, range check, sector and remainder
    logic [HUE_W-1:0]   w_hue_c;
    logic [PCT_W-1:0]   w_sat_c, w_val_c;
    logic [2:0]         w_cnt;
    logic [HUE_W-1:0]   w_rem9;
    t_side              n_side0;
    logic [PCT_W-1:0]   r_s1_sat, r_s1_val;
    logic [REM_W-1:0]   r_s1_rem;

    // stage 2: numerator terms over the common denominator
    logic [K_W-1:0]     w_kp, w_kq, w_kt;
    logic [PCT_W-1:0]   r_s2_val;
    logic [K_W-1:0]     r_s2_kp, r_s2_kq, r_s2_kt;

    // stage 3: terms times value
    logic [PROD_W-1:0]  r_s3_pv, r_s3_pp, r_s3_pq, r_s3_pt;

    // divider outputs
    logic [LEVEL_W-1:0] w_lv, w_lp, w_lq, w_lt;

    assign w_en        = ~r_out_vld | o_rgb.ready;
    // no item is taken while reset is held
    assign i_hsv.ready = w_en & i_rst_n;
    assign o_rgb.valid = r_out_vld;
    assign o_rgb.data  = r_out;

    always_comb begin
        w_hue_c = (i_hsv.data.hue_degrees > HUE_W'(HUE_MAX)) ?
                  HUE_W'(HUE_MAX) : i_hsv.data.hue_degrees;
        w_sat_c = (i_hsv.data.saturation_pct > PCT_W'(PCT_MAX)) ?
                  PCT_W'(PCT_MAX) : i_hsv.data.saturation_pct;
        w_val_c = (i_hsv.data.value_pct > PCT_W'(PCT_MAX)) ?
                  PCT_W'(PCT_MAX) : i_hsv.data.value_pct;
        // sector count by independent threshold compares, 0 to 6
        w_cnt = 3'd0;
        for (int i = 1; i <= int'(SECTORS); i++) begin
            w_cnt = w_cnt + 3'(w_hue_c >= HUE_W'(i * int'(SECTOR_DEG)));
        end
        w_rem9 = w_hue_c - HUE_W'(int'(w_cnt) * int'(SECTOR_DEG));
        n_side0.led_on   = i_hsv.data.led_on;
        n_side0.in_range = (i_hsv.data.hue_degrees <= HUE_W'(HUE_MAX)) &&
                           (i_hsv.data.saturation_pct <= PCT_W'(PCT_MAX)) &&
                           (i_hsv.data.value_pct <= PCT_W'(PCT_MAX));
        // full circle wraps back to the red sector
        n_side0.sector   = (w_cnt == 3'(SECTORS)) ? SEC_R_Y : t_sector'(w_cnt);
    end

    // p, q and t numerators; v is the constant full scale term
    always_comb begin
        w_kp = (K_W'(PCT_MAX) - K_W'(r_s1_sat)) * K_W'(SECTOR_DEG);
        w_kq = K_W'(K_FULL) - K_W'(r_s1_sat) * K_W'(r_s1_rem);
        w_kt = K_W'(K_FULL) - K_W'(r_s1_sat) * (K_W'(SECTOR_DEG) - K_W'(r_s1_rem));
    end

    // valid bits, cleared on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_vld     <= {r_vld[DEPTH-2:0], i_hsv.valid};
            r_out_vld <= r_vld[DEPTH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= n_side0;
            for (int i = 1; i < DEPTH; i++) begin
                r_side[i] <= r_side[i-1];
            end
            r_s1_sat <= w_sat_c;
            r_s1_val <= w_val_c;
            r_s1_rem <= w_rem9[REM_W-1:0];
            r_s2_val <= r_s1_val;
            r_s2_kp  <= w_kp;
            r_s2_kq  <= w_kq;
            r_s2_kt  <= w_kt;
            r_s3_pv  <= PROD_W'(r_s2_val) * PROD_W'(K_FULL);
            r_s3_pp  <= PROD_W'(r_s2_val) * PROD_W'(r_s2_kp);
            r_s3_pq  <= PROD_W'(r_s2_val) * PROD_W'(r_s2_kq);
            r_s3_pt  <= PROD_W'(r_s2_val) * PROD_W'(r_s2_kt);
            r_out    <= n_out;
        end
    end

    hsvc_scale #(.FRAC_BITS(FRAC_BITS)) u_scale_v (
        .i_clk(i_clk), .i_en(w_en), .i_prod(r_s3_pv), .o_level(w_lv)
    );
    hsvc_scale #(.FRAC_BITS(FRAC_BITS)) u_scale_p (
        .i_clk(i_clk), .i_en(w_en), .i_prod(r_s3_pp), .o_level(w_lp)
    );
    hsvc_scale #(.FRAC_BITS(FRAC_BITS)) u_scale_q (
        .i_clk(i_clk), .i_en(w_en), .i_prod(r_s3_pq), .o_level(w_lq)
    );
    hsvc_scale #(.FRAC_BITS(FRAC_BITS)) u_scale_t (
        .i_clk(i_clk), .i_en(w_en), .i_prod(r_s3_pt), .o_level(w_lt)
    );

    // sector routing; zero saturation needs no special path since p, q and t equal v
    always_comb begin
        n_out.in_range = r_side[DEPTH-1].in_range;
        case (r_side[DEPTH-1].sector)
            SEC_R_Y: begin
                n_out.red_level = w_lv; n_out.green_level = w_lt; n_out.blue_level = w_lp;
            end
            SEC_Y_G: begin
                n_out.red_level = w_lq; n_out.green_level = w_lv; n_out.blue_level = w_lp;
            end
            SEC_G_C: begin
                n_out.red_level = w_lp; n_out.green_level = w_lv; n_out.blue_level = w_lt;
            end
            SEC_C_B: begin
                n_out.red_level = w_lp; n_out.green_level = w_lq; n_out.blue_level = w_lv;
            end
            SEC_B_M: begin
                n_out.red_level = w_lt; n_out.green_level = w_lp; n_out.blue_level = w_lv;
            end
            default: begin
                n_out.red_level = w_lv; n_out.green_level = w_lp; n_out.blue_level = w_lq;
            end
        endcase
        // led off forces black
        if (!r_side[DEPTH-1].led_on) begin
            n_out.red_level   = '0;
            n_out.green_level = '0;
            n_out.blue_level  = '0;
        end
    end

endmodule

`default_nettype wire
